// ===== hw/rtl/tpr_pkg.sv =====
package tpr_pkg;

  localparam int unsigned DEF_NUM_STATES  = 16;
  localparam int unsigned DEF_NUM_SYMBOLS = 16;
  localparam int unsigned DEF_STACK_DEPTH = 64;
  localparam int unsigned DEF_MAX_STRING  = 4;

  localparam logic [7:0] EPSILON_BYTE = 8'd126;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_FEED = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  symbol;
    logic [3:0]  entry_state;
    logic [3:0]  next_state;
    logic [31:0] pop_bytes;
    logic [2:0]  pop_count;
    logic [31:0] push_bytes;
    logic [2:0]  push_count;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic       mismatch;
    logic       overflow;
    logic [6:0] final_depth;
  } out_t;

  // One transition table entry.
  typedef struct packed {
    logic [3:0]  next_state;
    logic [2:0]  pop_count;
    logic [2:0]  push_count;
    logic [31:0] pop_bytes;
    logic [31:0] push_bytes;
  } entry_t;

  // Shift command shared by every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

endpackage

// ===== hw/rtl/tpr_cell.sv =====
module tpr_cell
  import tpr_pkg::*;
(
  input  logic       clk,
  input  stack_ctl_t ctl,
  input  logic [7:0] from_up,
  input  logic [7:0] from_down,
  output logic [7:0] data
);

  // On a push each cell takes its upper neighbor's byte, on a pop its lower one's.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data <= from_up;
    end else if (ctl.pop) begin
      data <= from_down;
    end
  end

endmodule

// ===== hw/rtl/tpr_stack.sv =====
module tpr_stack
  import tpr_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic       clk,
  input  stack_ctl_t ctl,
  input  logic [7:0] push_byte,
  output logic [7:0] top
);

  logic [7:0] data [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] up_byte;
    logic [7:0] down_byte;

    if (i == 0) begin : g_first
      assign up_byte = push_byte;
    end else begin : g_mid
      assign up_byte = data[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_byte = data[i];
    end else begin : g_inner
      assign down_byte = data[i+1];
    end

    tpr_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_up   (up_byte),
      .from_down (down_byte),
      .data      (data[i])
    );
  end

  assign top = data[0];

endmodule

// ===== hw/rtl/tpr_table.sv =====
module tpr_table
  import tpr_pkg::*;
#(
  parameter int unsigned ENTRIES = DEF_NUM_STATES * DEF_NUM_SYMBOLS,
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/table_pushdown_recognizer.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    in_data   (in_t)
// out       output     out_valid / out_stall  out_data  (out_t)
// cfg       input      cfg_we                 cfg_wdata (start state)
//
// A load item and an end-of-word item are handled without leaving the idle state.
// A fed symbol occupies the block: after it is accepted, the block reads the table,
// takes one step per pop byte and per push byte, and closes each of the pop and push
// phases in a step of its own. A mismatch or overflow ends it early.
// Reset is synchronous; it empties the stack and sets the start state to zero.
// An input item is held off while a symbol is in work or a start state is written; an
// end-of-word item is also held off while the previous result waits on a stall.
module table_pushdown_recognizer
  import tpr_pkg::*;
#(
  parameter int unsigned NUM_STATES  = DEF_NUM_STATES,
  parameter int unsigned NUM_SYMBOLS = DEF_NUM_SYMBOLS,
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned MAX_STRING  = DEF_MAX_STRING
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  localparam int unsigned ENTRIES   = NUM_STATES * NUM_SYMBOLS;
  localparam int unsigned AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned STR_LIMIT = (MAX_STRING < 4) ? MAX_STRING : 4;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_POP  = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t           state;
  logic [3:0]       start_state;
  logic [3:0]       cur_state;
  logic [CNT_W-1:0] depth;
  logic             fail_mm;
  logic             fail_ov;
  logic [31:0]      pop_sh;
  logic [31:0]      push_sh;
  logic [2:0]       pop_left;
  logic [2:0]       push_left;

  logic       in_fire;
  logic       out_fire;
  logic       feed_go;
  logic       load_ok;
  logic       tbl_we;
  logic       tbl_re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  entry_t     wentry;
  entry_t     rentry;
  stack_ctl_t ctl;
  logic [7:0] top;
  logic [7:0] pop_b;
  logic [7:0] push_b;

  // Stall while a symbol is in work or a start state is written. Only an end-of-word
  // item needs the result register, so only it waits for a stalled result.
  assign in_stall = (state != S_IDLE) || cfg_we ||
                    (out_valid && out_stall && (in_data.action == ACT_END));
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  // Loads with a key outside the table are dropped, as are feeds after a failure or off the table.
  assign load_ok = (32'(in_data.symbol) < NUM_SYMBOLS) &&
                   (32'(in_data.entry_state) < NUM_STATES);
  assign feed_go = !fail_mm && !fail_ov &&
                   (32'(in_data.symbol) < NUM_SYMBOLS) &&
                   (32'(cur_state) < NUM_STATES);

  assign tbl_we = in_fire && (in_data.action == ACT_LOAD) && load_ok;
  assign tbl_re = in_fire && (in_data.action == ACT_FEED) && feed_go;
  assign waddr  = AW'(32'(in_data.symbol) * NUM_STATES + 32'(in_data.entry_state));
  assign raddr  = AW'(32'(in_data.symbol) * NUM_STATES + 32'(cur_state));

  // Counts beyond the string limit are saturated as the entry is stored.
  always_comb begin
    wentry.next_state = in_data.next_state;
    wentry.pop_count  = (32'(in_data.pop_count) > STR_LIMIT) ? 3'(STR_LIMIT)
                                                             : in_data.pop_count;
    wentry.push_count = (32'(in_data.push_count) > STR_LIMIT) ? 3'(STR_LIMIT)
                                                              : in_data.push_count;
    wentry.pop_bytes  = in_data.pop_bytes;
    wentry.push_bytes = in_data.push_bytes;
  end

  tpr_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (waddr),
    .wdata (wentry),
    .re    (tbl_re),
    .raddr (raddr),
    .rdata (rentry)
  );

  // The byte in work is always the low byte of its shift register.
  assign pop_b  = pop_sh[7:0];
  assign push_b = push_sh[7:0];

  // A pop shifts the chain up only when the byte is real, the stack has
  // something, and the top matches. A push of a real byte shifts it down while there is room.
  always_comb begin
    ctl.pop  = (state == S_POP) && (pop_left != 3'd0) && (pop_b != EPSILON_BYTE) &&
               (depth != '0) && (top == pop_b);
    ctl.push = (state == S_PUSH) && (push_left != 3'd0) && (push_b != EPSILON_BYTE) &&
               (depth != CNT_W'(STACK_DEPTH));
  end

  tpr_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .ctl       (ctl),
    .push_byte (push_b),
    .top       (top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      start_state <= 4'd0;
      cur_state   <= 4'd0;
      depth       <= '0;
      fail_mm     <= 1'b0;
      fail_ov     <= 1'b0;
      out_valid   <= 1'b0;
      pop_left    <= 3'd0;
      push_left   <= 3'd0;
    end else begin
      // A new result may replace one that leaves in the same cycle.
      if (in_fire && (in_data.action == ACT_END)) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        // A start state write also restarts the word in progress.
        state       <= S_IDLE;
        start_state <= cfg_wdata;
        cur_state   <= cfg_wdata;
        depth       <= '0;
        fail_mm     <= 1'b0;
        fail_ov     <= 1'b0;
      end else begin
        case (state)
          S_IDLE: begin
            if (in_fire) begin
              if ((in_data.action == ACT_FEED) && feed_go) begin
                state <= S_LOOK;
              end else if (in_data.action == ACT_END) begin
                // Report the word, then start over with an empty stack.
                out_data.accepted    <= (depth == '0) && !fail_mm && !fail_ov;
                out_data.mismatch    <= fail_mm;
                out_data.overflow    <= fail_ov;
                out_data.final_depth <= 7'(depth);
                cur_state            <= start_state;
                depth                <= '0;
                fail_mm              <= 1'b0;
                fail_ov              <= 1'b0;
              end
            end
          end
          S_LOOK: begin
            cur_state <= rentry.next_state;
            pop_sh    <= rentry.pop_bytes;
            push_sh   <= rentry.push_bytes;
            pop_left  <= rentry.pop_count;
            push_left <= rentry.push_count;
            state     <= S_POP;
          end
          S_POP: begin
            if (pop_left == 3'd0) begin
              state <= S_PUSH;
            end else if ((pop_b != EPSILON_BYTE) && (depth != '0) && (top != pop_b)) begin
              // Pops already done stay done; the rest of the word is ignored.
              fail_mm <= 1'b1;
              state   <= S_IDLE;
            end else begin
              if (ctl.pop) begin
                depth <= depth - 1'b1;
              end
              pop_sh   <= pop_sh >> 8;
              pop_left <= pop_left - 3'd1;
            end
          end
          S_PUSH: begin
            if (push_left == 3'd0) begin
              state <= S_IDLE;
            end else if ((push_b != EPSILON_BYTE) && (depth == CNT_W'(STACK_DEPTH))) begin
              fail_ov <= 1'b1;
              state   <= S_IDLE;
            end else begin
              if (ctl.push) begin
                depth <= depth + 1'b1;
              end
              push_sh   <= push_sh >> 8;
              push_left <= push_left - 3'd1;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/tpr_check.sv =====
module tpr_check
  import tpr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input in_t        in_data,
  input logic       out_valid,
  input logic       out_stall,
  input out_t       out_data
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An accepted word carries no failure and an empty stack.
  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted |->
      !out_data.mismatch && !out_data.overflow && (out_data.final_depth == 7'd0))
    else $error("accepted word with failure or leftover stack");

  // The first failure ends the word, so both flags never show together.
  a_one_failure: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.mismatch && out_data.overflow))
    else $error("both failure flags set");

  // An accepted end-of-word item yields its result on the next cycle.
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.action == ACT_END) |=> out_valid)
    else $error("end of word gave no result");

endmodule

bind table_pushdown_recognizer tpr_check u_check (.*);

// ===== tb/table_pushdown_recognizer_test.sv =====
module table_pushdown_recognizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // The drain covers the longest time a fed symbol can hold the block after it is accepted.
  localparam int unsigned DRAIN_CYCLES = 16;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [3:0] cfg_wdata;

  table_pushdown_recognizer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shadow copy of the recognizer. The stack and the transition table are kept at
  // the block's widths; a valid bit per table entry tells which keys were loaded.
  logic [7:0]  stack_mem [64];
  int unsigned stack_depth_now;
  logic [3:0]  state_now;
  logic [3:0]  start_reg;
  logic        hit_mismatch;
  logic        hit_overflow;
  entry_t      trans_table [256];
  bit          trans_loaded [256];

  out_t verdict_queue [$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          timed_out;

  function automatic logic [7:0] key_of(logic [3:0] sym, logic [3:0] st);
    return {sym, st};
  endfunction

  function automatic void restart_word();
    state_now = start_reg;
    stack_depth_now = 0;
    hit_mismatch = 1'b0;
    hit_overflow = 1'b0;
  endfunction

  // Applies one accepted item to the shadow copy and queues the verdict that an
  // end of word produces.
  function automatic void recognize(in_t item);
    entry_t e;
    logic [7:0] b;
    out_t v;
    case (item.action)
      ACT_LOAD: begin
        e.next_state = item.next_state;
        e.pop_count  = (item.pop_count > 3'd4) ? 3'd4 : item.pop_count;
        e.push_count = (item.push_count > 3'd4) ? 3'd4 : item.push_count;
        e.pop_bytes  = item.pop_bytes;
        e.push_bytes = item.push_bytes;
        trans_table[key_of(item.symbol, item.entry_state)] = e;
        trans_loaded[key_of(item.symbol, item.entry_state)] = 1'b1;
      end
      ACT_FEED: begin
        if (!hit_mismatch && !hit_overflow) begin
          e = trans_table[key_of(item.symbol, state_now)];
          state_now = e.next_state;
          for (int i = 0; i < e.pop_count; i++) begin
            b = e.pop_bytes[8*i +: 8];
            if (b != EPSILON_BYTE && stack_depth_now != 0) begin
              if (stack_mem[stack_depth_now-1] != b) begin
                hit_mismatch = 1'b1;
                return;
              end
              stack_depth_now--;
            end
          end
          for (int i = 0; i < e.push_count; i++) begin
            b = e.push_bytes[8*i +: 8];
            if (b != EPSILON_BYTE) begin
              if (stack_depth_now >= 64) begin
                hit_overflow = 1'b1;
                return;
              end
              stack_mem[stack_depth_now] = b;
              stack_depth_now++;
            end
          end
        end
      end
      ACT_END: begin
        v.accepted    = (stack_depth_now == 0) && !hit_mismatch && !hit_overflow;
        v.mismatch    = hit_mismatch;
        v.overflow    = hit_overflow;
        v.final_depth = stack_depth_now[6:0];
        verdict_queue.push_back(v);
        restart_word();
      end
      default: begin
      end
    endcase
  endfunction

  // A feed may only be sent while its key under the tracked state was loaded,
  // or while the word has already failed and the symbol will be ignored.
  function automatic bit feed_is_safe(logic [3:0] sym);
    return hit_mismatch || hit_overflow || trans_loaded[key_of(sym, state_now)];
  endfunction

  function automatic in_t make_item(logic [1:0] act, logic [3:0] sym, logic [3:0] st,
                                    logic [3:0] nxt, logic [31:0] pb, logic [2:0] pc,
                                    logic [31:0] qb, logic [2:0] qc);
    in_t t;
    t.action = act; t.symbol = sym; t.entry_state = st; t.next_state = nxt;
    t.pop_bytes = pb; t.pop_count = pc; t.push_bytes = qb; t.push_count = qc;
    return t;
  endfunction

  function automatic logic [7:0] rand_stack_byte();
    // Mostly a small alphabet so that pops match often, sometimes epsilon or any byte.
    case ($urandom_range(0, 9))
      0: return EPSILON_BYTE;
      1: return 8'($urandom);
      default: return 8'($urandom_range(65, 68));
    endcase
  endfunction

  function automatic logic [31:0] rand_string();
    return {rand_stack_byte(), rand_stack_byte(), rand_stack_byte(), rand_stack_byte()};
  endfunction

  // Sends one item, waiting out a random gap first, and updates the shadow copy
  // at the edge where it is accepted. Valid stays high after acceptance so that a
  // following item with no gap goes out at once; a gap or a drain drops it.
  task automatic send_item(in_t item);
    int unsigned gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    recognize(item);
  endtask

  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (verdict_queue.size() != 0 && !timed_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Configuration writes happen only with the block idle.
  task automatic write_start(logic [3:0] st);
    wait_for_verdicts();
    cfg_we <= 1'b1;
    cfg_wdata <= st;
    @(posedge clk);
    start_reg = st;
    restart_word();
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stall per item, checked field by field against the oldest verdict.
  initial begin
    out_t want;
    int unsigned hold;
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      hold = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (verdict_queue.size() == 0) begin
        $error("verdict arrived with none expected: %p", out_data);
        error_count++;
      end else begin
        want = verdict_queue.pop_front();
        if (out_data.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
          error_count++;
        end
        if (out_data.mismatch !== want.mismatch) begin
          $error("mismatch: expected %0d, got %0d", want.mismatch, out_data.mismatch);
          error_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_data.overflow);
          error_count++;
        end
        if (out_data.final_depth !== want.final_depth) begin
          $error("final_depth: expected %0d, got %0d", want.final_depth,
                 out_data.final_depth);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel accepts an item.
  initial begin
    idle_cycles = 0;
    timed_out = 1'b0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
        $display("table_pushdown_recognizer test failed");
        $finish;
      end
    end
  end

  typedef struct {
    in_t  item;
    bit   checked;
    out_t verdict;
  } directed_row_t;

  // Directed rows. Where a verdict is typed in, it is compared with the predicted one,
  // so a slip in the shadow copy cannot hide a fault in the block.
  directed_row_t directed [$];

  task automatic run_directed();
    out_t p;
    foreach (directed[i]) begin
      send_item(directed[i].item);
      if (directed[i].checked) begin
        p = verdict_queue[$];
        if (p !== directed[i].verdict) begin
          $error("directed row %0d: table verdict %p, predicted %p", i,
                 directed[i].verdict, p);
          error_count++;
        end
      end
    end
  endtask

  function automatic void add_row(in_t t, bit chk = 0, out_t v = '0);
    directed_row_t r;
    r.item = t; r.checked = chk; r.verdict = v;
    directed.push_back(r);
  endfunction

  // Random program: a few loaded transitions over a small state set, then words
  // of fed symbols that only follow loaded keys, sometimes broken by noise.
  task automatic run_random(int unsigned n_items);
    int unsigned sent;
    int unsigned word_len;
    logic [3:0] sym;
    int unsigned tries;
    sent = 0;
    while (sent < n_items && !timed_out) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(make_item(ACT_LOAD, 4'($urandom), 4'($urandom), 4'($urandom_range(0, 3)),
                            rand_string(), 3'($urandom), rand_string(), 3'($urandom)));
        sent++;
      end
      word_len = $urandom_range(0, 12);
      if ($urandom_range(0, 15) == 0) word_len = 40;
      for (int k = 0; k < word_len && sent < n_items; k++) begin
        tries = 0;
        do begin
          sym = 4'($urandom_range(0, 3));
          if ($urandom_range(0, 7) == 0) sym = 4'($urandom);
          tries++;
        end while (!feed_is_safe(sym) && tries < 32);
        if (feed_is_safe(sym)) begin
          send_item(make_item(ACT_FEED, sym, 4'($urandom), 4'($urandom), $urandom,
                              3'($urandom), $urandom, 3'($urandom)));
          sent++;
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        // Unused action: ignored, counts as noise.
        send_item(make_item(2'd3, 4'($urandom), 4'($urandom), 4'($urandom), $urandom,
                            3'($urandom), $urandom, 3'($urandom)));
      end
      send_item(make_item(ACT_END, 4'($urandom), 4'($urandom), 4'($urandom), $urandom,
                          3'($urandom), $urandom, 3'($urandom)));
      sent++;
    end
  endtask

  // Loads every (symbol, state) key the random words can reach from states 0..3.
  task automatic load_small_machine();
    for (int s = 0; s < 16; s++) begin
      for (int q = 0; q < 4; q++) begin
        send_item(make_item(ACT_LOAD, 4'(s), 4'(q), 4'($urandom_range(0, 3)),
                            rand_string(), 3'($urandom_range(0, 5)), rand_string(),
                            3'($urandom_range(0, 5))));
      end
    end
  endtask

  initial begin
    out_t ok_empty;
    out_t v;
    error_count = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    foreach (trans_loaded[i]) trans_loaded[i] = 1'b0;
    start_reg = '0;
    restart_word();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    ok_empty = '{accepted: 1'b1, mismatch: 1'b0, overflow: 1'b0, final_depth: 7'd0};

    // Empty word right after reset is accepted.
    add_row(make_item(ACT_END, 4'd0, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0), 1, ok_empty);
    // State 0, symbol 0: push "AB", go to 1. Counts above four saturate.
    add_row(make_item(ACT_LOAD, 4'd0, 4'd0, 4'd1, 32'h0, 3'd0, 32'h0000_4241, 3'd2));
    add_row(make_item(ACT_LOAD, 4'd1, 4'd1, 4'd2, 32'h4241_7E42, 3'd7, 32'h7E7E_7E7E, 3'd7));
    add_row(make_item(ACT_LOAD, 4'd15, 4'd15, 4'd15, 32'hFFFF_FFFF, 3'd4,
                      32'hFFFF_FFFF, 3'd4));
    add_row(make_item(ACT_LOAD, 4'd2, 4'd2, 4'd0, 32'h0000_00FF, 3'd1, 32'h0, 3'd0));
    // Push then pop with epsilon in between: balanced, accepted.
    add_row(make_item(ACT_FEED, 4'd0, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    add_row(make_item(ACT_FEED, 4'd1, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    add_row(make_item(ACT_END, 4'd0, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0), 1, ok_empty);
    // Word left with two bytes on the stack.
    add_row(make_item(ACT_FEED, 4'd0, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    v = '{accepted: 1'b0, mismatch: 1'b0, overflow: 1'b0, final_depth: 7'd2};
    add_row(make_item(ACT_END, 4'd0, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0), 1, v);
    // Mismatch: state 2 pops 0xFF against top "B"; later symbols ignored.
    add_row(make_item(ACT_LOAD, 4'd3, 4'd1, 4'd2, 32'h0, 3'd0, 32'h0, 3'd0));
    add_row(make_item(ACT_FEED, 4'd0, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    add_row(make_item(ACT_FEED, 4'd3, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    add_row(make_item(ACT_FEED, 4'd2, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    add_row(make_item(ACT_FEED, 4'd9, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    v = '{accepted: 1'b0, mismatch: 1'b1, overflow: 1'b0, final_depth: 7'd2};
    add_row(make_item(ACT_END, 4'd0, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0), 1, v);
    // Pop on an empty stack is skipped.
    add_row(make_item(ACT_LOAD, 4'd5, 4'd0, 4'd0, 32'h4142_4344, 3'd4, 32'h0, 3'd0));
    add_row(make_item(ACT_FEED, 4'd5, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    add_row(make_item(ACT_END, 4'd0, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0), 1, ok_empty);
    // Unused action gives nothing.
    add_row(make_item(2'd3, 4'd15, 4'd15, 4'd15, '1, 3'd7, '1, 3'd7));
    run_directed();

    // Overflow: four bytes per symbol, seventeen symbols exceed sixty-four.
    send_item(make_item(ACT_LOAD, 4'd6, 4'd0, 4'd0, 32'h0, 3'd0, 32'h4443_4241, 3'd4));
    for (int k = 0; k < 17; k++)
      send_item(make_item(ACT_FEED, 4'd6, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    send_item(make_item(ACT_END, 4'd0, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));

    // Start state extremes, with a restart in the middle of a word.
    write_start(4'd15);
    send_item(make_item(ACT_FEED, 4'd15, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    send_item(make_item(ACT_END, 4'd0, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    send_item(make_item(ACT_FEED, 4'd15, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));
    write_start(4'd0);
    send_item(make_item(ACT_END, 4'd0, 4'd0, 4'd0, '0, 3'd0, '0, 3'd0));

    load_small_machine();
    run_random(220);
    // The sender holds off until every verdict is in.
    wait_for_verdicts();
    write_start(4'($urandom_range(0, 3)));
    run_random(220);
    write_start(4'd3);
    run_random(50);

    wait_for_verdicts();
    if (error_count == 0 && verdict_queue.size() == 0) begin
      $display("table_pushdown_recognizer test passed");
    end else begin
      $display("table_pushdown_recognizer test failed");
    end
    $finish;
  end

endmodule
